@@ rtl/sird_pkg.sv @@
// ----------------------------------------------------------------------------
// sird_pkg: shared types and constants for signed integer to radix digits
// Field widths, register indexes, reset values, special characters and the
// classification record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package sird_pkg;

	// Fixed field widths
	localparam int VALUE_W     = 32;
	localparam int SYMBOL_W    = 8;
	localparam int RADIX_W     = 5;
	localparam int SYMBOLS_W   = 64;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 2;
	localparam int SYMBOL_CNT  = 16;
	localparam int SLOT_W      = 4;

	// Default parameter values
	localparam int DEFAULT_MAX_RADIX  = 16;
	localparam int DEFAULT_VALUE_BITS = 32;
	localparam int QUEUE_DEPTH        = 2;

	// Register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_RADIX        = 2'd0,
		REG_SYMBOLS_LOW  = 2'd1,
		REG_SYMBOLS_HIGH = 2'd2
	} cfg_reg_t;

	// Reset values: radix 10, alphabet "0123456789ABCDEF"
	localparam logic [RADIX_W-1:0]   RESET_RADIX        = 5'd10;
	localparam logic [SYMBOLS_W-1:0] RESET_SYMBOLS_LOW  = 64'h3736353433323130;
	localparam logic [SYMBOLS_W-1:0] RESET_SYMBOLS_HIGH = 64'h4645444342413938;

	// Special characters
	localparam logic [SYMBOL_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [SYMBOL_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [SYMBOL_W-1:0] CHAR_LF    = 8'h0A;
	localparam logic [SYMBOL_W-1:0] CHAR_VT    = 8'h0B;
	localparam logic [SYMBOL_W-1:0] CHAR_FF    = 8'h0C;
	localparam logic [SYMBOL_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [SYMBOL_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [SYMBOL_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [SYMBOL_W-1:0] CHAR_MINUS = 8'h2D;

	// Classification of one accepted value
	typedef struct packed {
		logic bad;   // alphabet invalid: one error result
		logic neg;   // value negative: leading minus
	} item_class_t;

	// Pick the symbol byte for digit slot d
	function automatic logic [SYMBOL_W-1:0] symbol_at(
		input logic [SYMBOLS_W-1:0] lo,
		input logic [SYMBOLS_W-1:0] hi,
		input logic [SLOT_W-1:0]    d
	);
		logic [SYMBOLS_W-1:0] word;
		word = d[SLOT_W-1] ? hi : lo;
		return word[8*d[SLOT_W-2:0] +: SYMBOL_W];
	endfunction

endpackage

@@ rtl/sird_front.sv @@
// ----------------------------------------------------------------------------
// sird_front: front end of the radix converter
// Takes the start transaction, checks the alphabet, splits the value into
// sign and exact magnitude and pushes the record into the queue.
// ----------------------------------------------------------------------------
module sird_front #(
	parameter int MAX_RADIX  = sird_pkg::DEFAULT_MAX_RADIX,
	parameter int VALUE_BITS = sird_pkg::DEFAULT_VALUE_BITS
) (
	input  logic                           start,
	input  logic [sird_pkg::VALUE_W-1:0]   value,
	input  logic                           full,
	input  logic [sird_pkg::RADIX_W-1:0]   radix,
	input  logic [sird_pkg::SYMBOLS_W-1:0] symbols_low,
	input  logic [sird_pkg::SYMBOLS_W-1:0] symbols_high,
	output logic                           busy,
	output logic                           push,
	output sird_pkg::item_class_t          cls,
	output logic [VALUE_BITS-1:0]          mag
);
	import sird_pkg::*;

	logic [SYMBOL_W-1:0]   sym [SYMBOL_CNT];
	logic [SYMBOL_CNT-1:0] used;
	logic                  bad;
	logic [VALUE_BITS-1:0] v;

	// Hold off new transactions while the queue is full
	assign busy = full;
	assign push = start && !full;

	// Check the alphabet: radix range, forbidden bytes, duplicates
	always_comb begin
		bad = (radix < RADIX_W'(2)) || (radix > RADIX_W'(MAX_RADIX));
		for (int i = 0; i < SYMBOL_CNT; i++) begin
			sym[i]  = symbol_at(symbols_low, symbols_high, SLOT_W'(i));
			used[i] = RADIX_W'(i) < radix;
		end
		for (int i = 0; i < SYMBOL_CNT; i++) begin
			if (used[i] && (sym[i] == CHAR_NUL || sym[i] == CHAR_PLUS ||
				sym[i] == CHAR_MINUS || sym[i] == CHAR_SPACE || sym[i] == CHAR_TAB ||
				sym[i] == CHAR_LF || sym[i] == CHAR_VT || sym[i] == CHAR_FF ||
				sym[i] == CHAR_CR)) begin
				bad = 1'b1;
			end
			for (int j = i + 1; j < SYMBOL_CNT; j++) begin
				if (used[j] && sym[i] == sym[j]) begin
					bad = 1'b1;
				end
			end
		end
	end

	// Split into sign and magnitude; the most negative value fits unsigned
	assign v       = value[VALUE_BITS-1:0];
	assign cls.bad = bad;
	assign cls.neg = v[VALUE_BITS-1];
	assign mag     = v[VALUE_BITS-1] ? (~v + 1'b1) : v;

endmodule

@@ rtl/sird_queue.sv @@
// ----------------------------------------------------------------------------
// sird_queue: short queue between front end and back end
// Register-based FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module sird_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = sird_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);
	import sird_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/sird_back.sv @@
// ----------------------------------------------------------------------------
// sird_back: back end of the radix converter
// Divides the magnitude by the radix eight bits a cycle, keeps the digits
// least significant first, then emits minus sign and digits most
// significant first, one character per cycle; an invalid alphabet gives one error result instead.
// ----------------------------------------------------------------------------
module sird_back #(
	parameter int MAX_RADIX  = sird_pkg::DEFAULT_MAX_RADIX,
	parameter int VALUE_BITS = sird_pkg::DEFAULT_VALUE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [sird_pkg::RADIX_W-1:0]   radix,
	input  logic [sird_pkg::SYMBOLS_W-1:0] symbols_low,
	input  logic [sird_pkg::SYMBOLS_W-1:0] symbols_high,
	input  logic                           avail,
	input  sird_pkg::item_class_t          cls,
	input  logic [VALUE_BITS-1:0]          mag,
	output logic                           pop,
	output logic                           strobe,
	output logic [sird_pkg::SYMBOL_W-1:0]  symbol,
	output logic                           last,
	output logic                           bad_alphabet
);
	import sird_pkg::*;

	localparam int DIGIT_W    = (MAX_RADIX > 2) ? $clog2(MAX_RADIX) : 1;
	localparam int STEP_BITS  = 8;
	localparam int NCHUNK     = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
	localparam int DIV_W      = NCHUNK * STEP_BITS;
	localparam int CHUNK_W    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
	localparam int IDX_W      = $clog2(VALUE_BITS);
	localparam int TRIAL_W    = RADIX_W + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	state_t                       state_q;
	logic [DIV_W-1:0]             div_q;
	logic [DIGIT_W-1:0]           rem_q;
	logic [CHUNK_W-1:0]           chunk_q;
	logic [IDX_W-1:0]             nd_q;
	logic [IDX_W-1:0]             ptr_q;
	logic                         neg_q;
	logic [DIGIT_W-1:0]           digit_q [VALUE_BITS];

	logic [STEP_BITS-1:0]         top;
	logic [STEP_BITS-1:0]         qbits;
	logic [DIGIT_W-1:0]           rem_w;
	logic [TRIAL_W-1:0]           trial;
	logic [DIV_W+STEP_BITS-1:0]   shifted;
	logic [DIV_W-1:0]             div_next;
	logic                         chunk_end;
	logic                         div_end;

	assign pop = (state_q == ST_IDLE) && avail;

	// Eight restoring division steps on the top byte of the dividend
	always_comb begin
		top   = div_q[DIV_W-1 -: STEP_BITS];
		rem_w = rem_q;
		qbits = '0;
		trial = '0;
		for (int k = STEP_BITS - 1; k >= 0; k--) begin
			trial = TRIAL_W'({rem_w, top[k]});
			if (trial >= TRIAL_W'(radix)) begin
				qbits[k] = 1'b1;
				trial    = trial - TRIAL_W'(radix);
			end
			rem_w = trial[DIGIT_W-1:0];
		end
		shifted  = {div_q, qbits};
		div_next = shifted[DIV_W-1:0];
	end

	assign chunk_end = chunk_q == CHUNK_W'(NCHUNK - 1);
	assign div_end   = chunk_end && (div_next == '0 || nd_q == IDX_W'(VALUE_BITS - 1));

	// Sequence the item and drive registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			strobe       <= 1'b0;
			symbol       <= '0;
			last         <= 1'b0;
			bad_alphabet <= 1'b0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (avail) begin
						if (cls.bad) begin
							strobe       <= 1'b1;
							symbol       <= CHAR_NUL;
							last         <= 1'b1;
							bad_alphabet <= 1'b1;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_end) begin
						state_q <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					strobe       <= 1'b1;
					symbol       <= CHAR_MINUS;
					last         <= 1'b0;
					bad_alphabet <= 1'b0;
					state_q      <= ST_EMIT;
				end
				ST_EMIT: begin
					strobe       <= 1'b1;
					symbol       <= symbol_at(symbols_low, symbols_high,
						SLOT_W'(digit_q[ptr_q]));
					last         <= ptr_q == '0;
					bad_alphabet <= 1'b0;
					if (ptr_q == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Divider datapath and digit store
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				div_q   <= DIV_W'(mag);
				rem_q   <= '0;
				chunk_q <= '0;
				nd_q    <= '0;
				neg_q   <= cls.neg;
			end
			ST_DIV: begin
				div_q <= div_next;
				if (chunk_end) begin
					digit_q[nd_q] <= rem_w;
					rem_q         <= '0;
					chunk_q       <= '0;
					if (div_end) begin
						ptr_q <= nd_q;
					end else begin
						nd_q <= nd_q + 1'b1;
					end
				end else begin
					rem_q   <= rem_w;
					chunk_q <= chunk_q + 1'b1;
				end
			end
			ST_EMIT: begin
				if (ptr_q != '0) begin
					ptr_q <= ptr_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ rtl/signed_int_to_radix_digits.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_radix_digits: signed integer to text in a configured radix
// Converts each value into its characters, most significant digit first,
// with a leading minus for negatives, using a configurable digit alphabet.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake          Payload                         Width
//   input     start / busy       value                           32
//   result    strobe             symbol, last, bad_alphabet      8, 1, 1
//   config    wr_en              wr_index, wr_data               2, 64
//
// A transaction is taken when start is high and busy is low; a two-entry
// queue lets up to two values wait while the back end works.
// Each digit is worked out in the shared divider, then the characters go out
// one per cycle, the minus sign first for negatives.
// An invalid alphabet gives one error result in the cycle after the pop.
// Results are strobed for one cycle and cannot be stalled. Reset clears
// control state and restores radix 10 with the alphabet 0-9, A-F.
//
module signed_int_to_radix_digits #(
	parameter int MAX_RADIX  = sird_pkg::DEFAULT_MAX_RADIX,
	parameter int VALUE_BITS = sird_pkg::DEFAULT_VALUE_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [sird_pkg::VALUE_W-1:0]     value,
	output logic                             busy,
	output logic                             strobe,
	output logic [sird_pkg::SYMBOL_W-1:0]    symbol,
	output logic                             last,
	output logic                             bad_alphabet,
	input  logic                             wr_en,
	input  logic [sird_pkg::CFG_INDEX_W-1:0] wr_index,
	input  logic [sird_pkg::CFG_DATA_W-1:0]  wr_data
);
	import sird_pkg::*;

	localparam int CLASS_W = $bits(item_class_t);
	localparam int ENTRY_W = CLASS_W + VALUE_BITS;

	logic [RADIX_W-1:0]    radix_q;
	logic [SYMBOLS_W-1:0]  symbols_low_q;
	logic [SYMBOLS_W-1:0]  symbols_high_q;

	logic                  full;
	logic                  empty;
	logic                  push;
	logic                  pop;
	item_class_t           push_cls;
	logic [VALUE_BITS-1:0] push_mag;
	logic [ENTRY_W-1:0]    head;
	item_class_t           head_cls;
	logic [VALUE_BITS-1:0] head_mag;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q        <= RESET_RADIX;
			symbols_low_q  <= RESET_SYMBOLS_LOW;
			symbols_high_q <= RESET_SYMBOLS_HIGH;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RADIX:        radix_q        <= wr_data[RADIX_W-1:0];
				REG_SYMBOLS_LOW:  symbols_low_q  <= wr_data;
				REG_SYMBOLS_HIGH: symbols_high_q <= wr_data;
				default: begin
				end
			endcase
		end
	end

	sird_front #(
		.MAX_RADIX  (MAX_RADIX),
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.start        (start),
		.value        (value),
		.full         (full),
		.radix        (radix_q),
		.symbols_low  (symbols_low_q),
		.symbols_high (symbols_high_q),
		.busy         (busy),
		.push         (push),
		.cls          (push_cls),
		.mag          (push_mag)
	);

	sird_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_cls, push_mag}),
		.pop       (pop),
		.pop_data  (head),
		.full      (full),
		.empty     (empty)
	);

	// Unpack the queue head
	assign head_cls = item_class_t'(head[ENTRY_W-1 -: CLASS_W]);
	assign head_mag = head[VALUE_BITS-1:0];

	sird_back #(
		.MAX_RADIX  (MAX_RADIX),
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.radix        (radix_q),
		.symbols_low  (symbols_low_q),
		.symbols_high (symbols_high_q),
		.avail        (!empty),
		.cls          (head_cls),
		.mag          (head_mag),
		.pop          (pop),
		.strobe       (strobe),
		.symbol       (symbol),
		.last         (last),
		.bad_alphabet (bad_alphabet)
	);

endmodule

@@ tb/sird_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sird_checker: scoreboard for signed_int_to_radix_digits
// Mirrors the three configuration registers, predicts the character stream of
// every accepted value and compares each strobed result, in order, against
// the oldest predicted character. Reports a running mismatch count.
// ----------------------------------------------------------------------------
module sird_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  logic [sird_pkg::VALUE_W-1:0]     value,
	input  logic                             strobe,
	input  logic [sird_pkg::SYMBOL_W-1:0]    symbol,
	input  logic                             last,
	input  logic                             bad_alphabet,
	input  logic                             wr_en,
	input  logic [sird_pkg::CFG_INDEX_W-1:0] wr_index,
	input  logic [sird_pkg::CFG_DATA_W-1:0]  wr_data,
	output int                               errors,
	output int                               pending,
	output int                               chars_checked
);
	import sird_pkg::*;

	localparam int MAX_RADIX = DEFAULT_MAX_RADIX;

	// One predicted output character
	typedef struct packed {
		logic [SYMBOL_W-1:0] sym;
		logic                is_last;
		logic                is_bad;
	} text_char_t;

	text_char_t           expected_text[$];
	logic [RADIX_W-1:0]   radix_q;
	logic [SYMBOLS_W-1:0] sym_lo_q;
	logic [SYMBOLS_W-1:0] sym_hi_q;

	// Look up the symbol byte of digit d in the mirrored alphabet
	function automatic logic [SYMBOL_W-1:0] digit_symbol(input int d);
		logic [2*SYMBOLS_W-1:0] alphabet;
		alphabet = {sym_hi_q, sym_lo_q};
		return alphabet[SYMBOL_W*d +: SYMBOL_W];
	endfunction

	function automatic bit reserved_symbol(input logic [SYMBOL_W-1:0] c);
		return c == CHAR_NUL || c == CHAR_PLUS || c == CHAR_MINUS ||
			c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF ||
			c == CHAR_VT || c == CHAR_FF || c == CHAR_CR;
	endfunction

	// Radix in range, no reserved symbol and no repeat among the digits in use
	function automatic bit alphabet_valid();
		int r;
		r = int'(radix_q);
		if (r < 2 || r > MAX_RADIX)
			return 1'b0;
		for (int i = 0; i < r; i++) begin
			if (reserved_symbol(digit_symbol(i)))
				return 1'b0;
			for (int j = i + 1; j < r; j++)
				if (digit_symbol(j) == digit_symbol(i))
					return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void push_char(input logic [SYMBOL_W-1:0] sym, input logic is_last,
		input logic is_bad);
		text_char_t c;
		c.sym     = sym;
		c.is_last = is_last;
		c.is_bad  = is_bad;
		expected_text.push_back(c);
	endfunction

	// Expand one value into its characters, most significant digit first
	function automatic void predict_text(input logic [VALUE_W-1:0] v);
		logic [VALUE_W-1:0] mag;
		logic [VALUE_W-1:0] r;
		int                 digits[$];
		if (!alphabet_valid()) begin
			push_char(CHAR_NUL, 1'b1, 1'b1);
			return;
		end
		r   = VALUE_W'(radix_q);
		mag = v[VALUE_W-1] ? -v : v;
		do begin
			digits.push_back(int'(mag % r));
			mag = mag / r;
		end while (mag != '0);
		if (v[VALUE_W-1])
			push_char(CHAR_MINUS, 1'b0, 1'b0);
		for (int i = digits.size() - 1; i >= 0; i--)
			push_char(digit_symbol(digits[i]), i == 0, 1'b0);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int         fails;
		text_char_t want;
		if (!arst_n) begin
			radix_q  <= RESET_RADIX;
			sym_lo_q <= RESET_SYMBOLS_LOW;
			sym_hi_q <= RESET_SYMBOLS_HIGH;
			expected_text.delete();
			errors        <= 0;
			pending       <= 0;
			chars_checked <= 0;
		end else begin
			fails = 0;

			// Compare a strobed character with the oldest prediction
			if (strobe) begin
				chars_checked <= chars_checked + 1;
				if (expected_text.size() == 0) begin
					fails++;
					$error("unexpected result: symbol %02h last %0b bad_alphabet %0b",
						symbol, last, bad_alphabet);
				end else begin
					want = expected_text.pop_front();
					if (symbol !== want.sym) begin
						fails++;
						$error("symbol mismatch: expected %02h, actual %02h", want.sym, symbol);
					end
					if (last !== want.is_last) begin
						fails++;
						$error("last mismatch: expected %0b, actual %0b", want.is_last, last);
					end
					if (bad_alphabet !== want.is_bad) begin
						fails++;
						$error("bad_alphabet mismatch: expected %0b, actual %0b",
							want.is_bad, bad_alphabet);
					end
				end
			end

			// Track register writes; the spare index is dropped
			if (wr_en) begin
				case (wr_index)
					REG_RADIX:        radix_q  <= wr_data[RADIX_W-1:0];
					REG_SYMBOLS_LOW:  sym_lo_q <= wr_data;
					REG_SYMBOLS_HIGH: sym_hi_q <= wr_data;
					default: ;
				endcase
			end

			// Predict the text of each accepted transaction
			if (start && !busy)
				predict_text(value);

			errors  <= errors + fails;
			pending <= expected_text.size();
		end
	end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for signed_int_to_radix_digits
// Drives directed corner values and alphabets, then random values under
// random valid and broken alphabets in three pacing phases. Checking is done
// by sird_checker; this module makes stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import sird_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int DRAIN_CYCLES  = 200;
	localparam int RANDOM_VALUES = 444;
	localparam int PHASES        = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

	logic                   clk;
	logic                   arst_n   = 1'b0;
	logic                   start    = 1'b0;
	logic [VALUE_W-1:0]     value    = '0;
	logic                   wr_en    = 1'b0;
	logic [CFG_INDEX_W-1:0] wr_index = '0;
	logic [CFG_DATA_W-1:0]  wr_data  = '0;
	logic                   busy;
	logic                   strobe;
	logic [SYMBOL_W-1:0]    symbol;
	logic                   last;
	logic                   bad_alphabet;

	int errors;
	int pending;
	int chars_checked;
	int cycles           = 0;
	int idle_pct         = 0;
	int values_sent      = 0;
	int alphabets_loaded = 0;

	signed_int_to_radix_digits uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.value        (value),
		.busy         (busy),
		.strobe       (strobe),
		.symbol       (symbol),
		.last         (last),
		.bad_alphabet (bad_alphabet),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	sird_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.value         (value),
		.strobe        (strobe),
		.symbol        (symbol),
		.last          (last),
		.bad_alphabet  (bad_alphabet),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.errors        (errors),
		.pending       (pending),
		.chars_checked (chars_checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [SYMBOL_W-1:0] reserved_char(input int k);
		case (k)
			0:       return CHAR_NUL;
			1:       return CHAR_PLUS;
			2:       return CHAR_SPACE;
			3:       return CHAR_TAB;
			4:       return CHAR_LF;
			5:       return CHAR_VT;
			6:       return CHAR_FF;
			7:       return CHAR_CR;
			default: return CHAR_MINUS;
		endcase
	endfunction

	// Mostly spread over all magnitudes, sometimes an extreme
	function automatic logic [VALUE_W-1:0] pick_value();
		int unsigned        width;
		logic [VALUE_W-1:0] v;
		if ($urandom_range(7) == 0) begin
			case ($urandom_range(4))
				0:       v = '0;
				1:       v = 32'h7FFF_FFFF;
				2:       v = 32'h8000_0000;
				3:       v = '1;
				default: v = 32'h0000_0001;
			endcase
		end else begin
			width = $urandom_range(32);
			v = (width == 0) ? '0 : ($urandom >> (32 - width));
			if ($urandom_range(1))
				v = -v;
		end
		return v;
	endfunction

	// Hold start high until the block takes the transaction
	task automatic send_value(input logic [VALUE_W-1:0] v);
		start <= 1'b1;
		value <= v;
		do
			@(posedge clk);
		while (busy);
		values_sent++;
	endtask

	// Idle the sender for a random stretch, now and then a long one
	task automatic sender_pause();
		int n;
		n = 0;
		while ($urandom_range(99) < idle_pct)
			n++;
		if (idle_pct != 0 && $urandom_range(24) == 0)
			n += $urandom_range(150, 1);
		if (n > 0) begin
			start <= 1'b0;
			value <= $urandom;
			repeat (n) @(posedge clk);
		end
	endtask

	// Drop start and wait until every predicted character has come out
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write the spare index, then radix and both symbol words, with the block idle
	task automatic load_alphabet(input logic [RADIX_W-1:0] r,
		input logic [SYMBOLS_W-1:0] lo, input logic [SYMBOLS_W-1:0] hi);
		logic [CFG_DATA_W-1:0] radix_word;
		settle();
		radix_word = {$urandom, $urandom};
		radix_word[RADIX_W-1:0] = r;
		wr_en    <= 1'b1;
		wr_index <= REG_SPARE;
		wr_data  <= {$urandom, $urandom};
		@(posedge clk);
		wr_index <= REG_RADIX;
		wr_data  <= radix_word;
		@(posedge clk);
		wr_index <= REG_SYMBOLS_LOW;
		wr_data  <= lo;
		@(posedge clk);
		wr_index <= REG_SYMBOLS_HIGH;
		wr_data  <= hi;
		@(posedge clk);
		wr_en <= 1'b0;
		alphabets_loaded++;
	endtask

	// Decimal default alphabet with one slot overwritten, then one value
	task automatic try_symbol(input int slot, input logic [SYMBOL_W-1:0] c,
		input logic [VALUE_W-1:0] v);
		logic [2*SYMBOLS_W-1:0] alphabet;
		alphabet = {RESET_SYMBOLS_HIGH, RESET_SYMBOLS_LOW};
		alphabet[SYMBOL_W*slot +: SYMBOL_W] = c;
		load_alphabet(RESET_RADIX, alphabet[SYMBOLS_W-1:0], alphabet[2*SYMBOLS_W-1:SYMBOLS_W]);
		send_value(v);
	endtask

	// Random alphabet: mostly valid, sometimes broken in one of several ways
	task automatic pick_alphabet(output logic [RADIX_W-1:0] r,
		output logic [SYMBOLS_W-1:0] lo, output logic [SYMBOLS_W-1:0] hi);
		logic [SYMBOL_W-1:0]    s [SYMBOL_CNT];
		logic [SYMBOL_W-1:0]    c;
		logic [2*SYMBOLS_W-1:0] alphabet;
		int                     kind;
		int                     pos;
		int                     other;
		bit                     fresh;
		case ($urandom_range(3))
			0:       r = RADIX_W'(2);
			1:       r = RADIX_W'(16);
			default: r = RADIX_W'($urandom_range(15, 3));
		endcase

		// Draw distinct symbols that are never reserved
		for (int i = 0; i < SYMBOL_CNT; i++) begin
			do begin
				case ($urandom_range(3))
					0:       c = SYMBOL_W'($urandom_range(8'h08, 8'h01));
					1:       c = SYMBOL_W'($urandom_range(8'h1F, 8'h0E));
					default: c = SYMBOL_W'($urandom_range(8'hFF, 8'h2E));
				endcase
				fresh = 1'b1;
				for (int j = 0; j < i; j++)
					if (s[j] == c)
						fresh = 1'b0;
			end while (!fresh);
			s[i] = c;
		end

		// Junk in slots past the radix must not matter
		for (int i = r; i < SYMBOL_CNT; i++)
			if ($urandom_range(1))
				s[i] = $urandom_range(1) ? reserved_char($urandom_range(8))
					: s[$urandom_range(r - 1)];

		// Break the alphabet now and then
		kind = $urandom_range(99);
		pos  = $urandom_range(r - 1);
		if (kind < 6) begin
			r = $urandom_range(1) ? RADIX_W'($urandom_range(1))
				: RADIX_W'($urandom_range(31, 17));
		end else if (kind < 12) begin
			s[pos] = reserved_char($urandom_range(8));
		end else if (kind < 18) begin
			other = $urandom_range(r - 2);
			if (other >= pos)
				other++;
			s[other] = s[pos];
		end

		for (int i = 0; i < SYMBOL_CNT; i++)
			alphabet[SYMBOL_W*i +: SYMBOL_W] = s[i];
		lo = alphabet[SYMBOLS_W-1:0];
		hi = alphabet[2*SYMBOLS_W-1:SYMBOLS_W];
	endtask

	initial begin
		logic [RADIX_W-1:0]   r;
		logic [SYMBOLS_W-1:0] lo;
		logic [SYMBOLS_W-1:0] hi;
		int                   burst;
		int                   sent;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// Decimal with the reset alphabet: zero, extremes, signs
		send_value(32'h0000_0000);
		send_value(32'h0000_0001);
		send_value(32'hFFFF_FFFF);
		send_value(32'h7FFF_FFFF);
		send_value(32'h8000_0000);
		send_value(32'd9);
		send_value(-32'sd10);
		send_value(32'd1234567890);

		// Binary: the most negative value gives the longest text
		load_alphabet(5'd2, RESET_SYMBOLS_LOW, RESET_SYMBOLS_HIGH);
		send_value(32'h8000_0000);
		send_value(32'h7FFF_FFFF);
		send_value(32'h0000_0000);

		// Hexadecimal, full alphabet
		load_alphabet(5'd16, RESET_SYMBOLS_LOW, RESET_SYMBOLS_HIGH);
		send_value(32'h8000_0000);
		send_value(32'hFFFF_FFFF);
		send_value(32'h00AB_CDEF);

		// Hexadecimal with high-bit symbol bytes
		load_alphabet(5'd16, 64'hF7F6_F5F4_F3F2_F1F0, 64'h8F8E_8D8C_8B8A_8988);
		send_value(32'hFEDC_BA98);

		// Radix 3: reserved bytes past the radix are fine
		load_alphabet(5'd3, 64'h0000_0000_2D7A_7978, '0);
		send_value(-32'sd5);

		// Broken alphabets: radix out of range, reserved symbols, duplicate
		load_alphabet(5'd1, RESET_SYMBOLS_LOW, RESET_SYMBOLS_HIGH);
		send_value(32'd42);
		load_alphabet(5'd17, RESET_SYMBOLS_LOW, RESET_SYMBOLS_HIGH);
		send_value(32'd42);
		try_symbol(5, CHAR_MINUS, -32'sd7);
		try_symbol(0, CHAR_PLUS, 32'd7);
		try_symbol(9, CHAR_SPACE, 32'd7);
		try_symbol(3, CHAR_TAB, 32'd7);
		try_symbol(1, CHAR_NUL, 32'd7);
		load_alphabet(5'd16, RESET_SYMBOLS_LOW, 64'h4645_4443_4241_3930);
		send_value(32'd123);

		// Random values under random alphabets, three pacing phases
		for (int phase = 0; phase < PHASES; phase++) begin
			idle_pct = (phase == 0) ? 7 : (phase == 1) ? 60 : 0;
			sent = 0;
			while (sent < RANDOM_VALUES / PHASES) begin
				pick_alphabet(r, lo, hi);
				load_alphabet(r, lo, hi);
				burst = $urandom_range(40, 10);
				if (burst > RANDOM_VALUES / PHASES - sent)
					burst = RANDOM_VALUES / PHASES - sent;
				repeat (burst) begin
					send_value(pick_value());
					sender_pause();
				end
				sent += burst;
			end
		end

		// Drain and give the verdict
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Converted %0d values under %0d alphabet settings, three pacing phases.",
			values_sent, alphabets_loaded);
		$display("Checked %0d output characters, %0d still outstanding, %0d mismatches.",
			chars_checked, pending, errors);
		if (errors == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ files.f @@
rtl/sird_pkg.sv
rtl/sird_front.sv
rtl/sird_queue.sv
rtl/sird_back.sv
rtl/signed_int_to_radix_digits.sv
tb/sird_checker.sv
tb/tb_top.sv
